@@ hdl/rled_pkg.sv @@
// Shared types and constants of the pair-escape run-length decoder.
// No dependencies; every other file in hdl/ imports this package.
package rled_pkg;

   localparam int DEF_COPIES_PER_RESULT = 8;
   localparam int DEF_LENGTH_WIDTH      = 24;
   localparam int BYTE_W                = 8;
   localparam int COPIES_W              = 4;
   localparam int QUEUE_DEPTH           = 2;

   // Chunk size is kept between 8 (a 255 run fits 32 results) and 15 (copies field).
   function automatic int chunk_size(input int requested);
      int c;
      c = requested;
      if (c < 8) c = 8;
      if (c > 15) c = 15;
      return c;
   endfunction

   typedef enum logic [2:0] {
      PH_EMPTY = 3'b001,
      PH_HELD  = 3'b010,
      PH_COUNT = 3'b100
   } phase_type;

   // One run handed from the front to the back.
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] count;   // already clipped, never zero
      logic              reached; // last chunk lands exactly on the length
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ hdl/rled_channels.sv @@
// Channel interfaces of the decoder: request, response and register write.
// Depends on rled_pkg for field widths.
interface rled_req_if;
   import rled_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_stream;
   modport source (output valid, in_byte, end_of_stream, input ready);
   modport sink (input valid, in_byte, end_of_stream, output ready);
endinterface

interface rled_rsp_if;
   import rled_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_value;
   logic [COPIES_W-1:0] copies;
   logic                last_of_item;
   logic                length_reached;
   modport source (output valid, out_value, copies, last_of_item, length_reached,
                   input ready);
   modport sink (input valid, out_value, copies, last_of_item, length_reached,
                 output ready);
endinterface

interface rled_csr_if #(parameter int LENGTH_WIDTH = rled_pkg::DEF_LENGTH_WIDTH);
   logic                    valid;
   logic                    ready;
   logic [LENGTH_WIDTH-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ hdl/rle_pair_escape_decoder.sv @@
// Top level of the pair-escape run-length decoder: length register, front,
// command queue and back. Depends on rled_pkg, rled_channels and the rled_ modules.
//
//   channel   direction  payload                                         transfer when
//   req_chan  in         in_byte, end_of_stream                          valid && ready
//   rsp_chan  out        out_value, copies, last_of_item, length_reached valid && ready
//   csr_chan  in         data (output length)                            valid && ready
//
// An input byte is taken whenever the two-entry command queue has room.
// A run of N bytes leaves the back end as ceil(N/chunk) responses, one per cycle
// while the sink keeps ready high, once the command is loaded from the queue.
// Synchronous reset clears phase, held byte, produced count and output length.
// A stalled sink fills the queue, and then req_chan.ready drops.
module rle_pair_escape_decoder #(
   parameter int COPIES_PER_RESULT = rled_pkg::DEF_COPIES_PER_RESULT,
   parameter int LENGTH_WIDTH      = rled_pkg::DEF_LENGTH_WIDTH
) (
   input logic  clock,
   input logic  reset,
   rled_req_if.sink                        req_chan,
   rled_rsp_if.source                      rsp_chan,
   rled_csr_if.sink                        csr_chan
);
   import rled_pkg::*;

   logic [LENGTH_WIDTH-1:0] length_ff;
   logic                    push;
   logic                    pop;
   cmd_type                 push_cmd;
   cmd_type                 head_cmd;
   q_status_type            q_status;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_chan.valid) begin
         length_ff <= csr_chan.data;
      end
   end

   rled_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_chan.valid),
      .in_ready      (req_chan.ready),
      .in_byte       (req_chan.in_byte),
      .end_of_stream (req_chan.end_of_stream),
      .length_limit  (length_ff),
      .q_status      (q_status),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   rled_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   rled_back #(.COPIES_PER_RESULT(COPIES_PER_RESULT)) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .q_status       (q_status),
      .pop            (pop),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .out_value      (rsp_chan.out_value),
      .copies         (rsp_chan.copies),
      .last_of_item   (rsp_chan.last_of_item),
      .length_reached (rsp_chan.length_reached)
   );

endmodule

@@ hdl/rled_front.sv @@
// Front end: accepts encoded bytes, tracks held byte and phase, clips runs
// at the output length and pushes run commands. Depends on rled_pkg.
module rled_front #(
   parameter int LENGTH_WIDTH = rled_pkg::DEF_LENGTH_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [rled_pkg::BYTE_W-1:0]  in_byte,
   input  logic                         end_of_stream,
   input  logic [LENGTH_WIDTH-1:0]      length_limit,
   input  rled_pkg::q_status_type       q_status,
   output logic                         push,
   output rled_pkg::cmd_type            push_cmd
);
   import rled_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [BYTE_W-1:0]       held_ff, held_in;
   logic [LENGTH_WIDTH-1:0] produced_ff, produced_in;
   logic [BYTE_W-1:0]       run_cnt;
   logic [LENGTH_WIDTH-1:0] rem;
   logic [BYTE_W-1:0]       clip;
   logic                    below;
   logic                    go;

   assign in_ready = !q_status.full;
   assign go       = in_valid && in_ready;
   assign below    = produced_ff < length_limit;
   assign rem      = length_limit - produced_ff;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      run_cnt  = '0;
      if (end_of_stream) begin
         case (phase_ff)
            PH_HELD:  run_cnt = BYTE_W'(1);
            PH_COUNT: run_cnt = BYTE_W'(2);
            default:  run_cnt = '0;
         endcase
         phase_in = PH_EMPTY;
      end else if (below) begin
         case (phase_ff)
            PH_HELD: begin
               if (in_byte == held_ff) begin
                  phase_in = PH_COUNT;
               end else begin
                  run_cnt = BYTE_W'(1);
                  held_in = in_byte;
               end
            end
            PH_COUNT: begin
               run_cnt  = in_byte;
               phase_in = PH_EMPTY;
            end
            default: begin
               held_in  = in_byte;
               phase_in = PH_HELD;
            end
         endcase
      end
   end

   // Clip the run to what is left of the output length.
   always_comb begin
      if (LENGTH_WIDTH'(run_cnt) > rem) begin
         clip = rem[BYTE_W-1:0];
      end else begin
         clip = run_cnt;
      end
      push             = go && below && (run_cnt != '0);
      push_cmd.value   = held_ff;
      push_cmd.count   = clip;
      push_cmd.reached = LENGTH_WIDTH'(run_cnt) >= rem;
      produced_in      = produced_ff + LENGTH_WIDTH'(clip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_EMPTY;
         held_ff     <= '0;
         produced_ff <= '0;
      end else if (go) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         if (push) begin
            produced_ff <= produced_in;
         end
      end
   end

endmodule

@@ hdl/rled_cmd_queue.sv @@
// Short run-command queue between front and back.
// Depends on rled_pkg for the command type and depth.
module rled_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rled_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output rled_pkg::cmd_type      head_cmd,
   output rled_pkg::q_status_type status
);
   import rled_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;

   assign status.full  = fill_ff == CNT_W'(QUEUE_DEPTH);
   assign status.empty = fill_ff == '0;
   assign head_cmd     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/rled_back.sv @@
// Back end: splits each run command into chunks and drives the registered
// response channel. Depends on rled_pkg.
module rled_back #(
   parameter int COPIES_PER_RESULT = rled_pkg::DEF_COPIES_PER_RESULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rled_pkg::cmd_type              head_cmd,
   input  rled_pkg::q_status_type         q_status,
   output logic                           pop,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [rled_pkg::BYTE_W-1:0]    out_value,
   output logic [rled_pkg::COPIES_W-1:0]  copies,
   output logic                           last_of_item,
   output logic                           length_reached
);
   import rled_pkg::*;

   localparam int CHUNK = chunk_size(COPIES_PER_RESULT);

   logic                busy_ff;
   logic [BYTE_W-1:0]   value_ff;
   logic [BYTE_W-1:0]   left_ff, left_in;
   logic                reached_ff;
   logic                vld_ff;
   logic [BYTE_W-1:0]   o_value_ff;
   logic [COPIES_W-1:0] o_copies_ff;
   logic                o_last_ff;
   logic                o_reached_ff;
   logic [BYTE_W-1:0]   chunk;
   logic                final_chunk;
   logic                out_free;
   logic                emit;

   assign out_free    = !vld_ff || out_ready;
   assign emit        = busy_ff && out_free;
   assign pop         = !busy_ff && !q_status.empty;
   assign final_chunk = left_ff <= BYTE_W'(CHUNK);
   assign chunk       = final_chunk ? left_ff : BYTE_W'(CHUNK);
   assign left_in     = left_ff - chunk;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= 1'b1;
         end else if (emit && final_chunk) begin
            busy_ff <= 1'b0;
         end
         if (emit) begin
            vld_ff <= 1'b1;
         end else if (out_ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         value_ff   <= head_cmd.value;
         left_ff    <= head_cmd.count;
         reached_ff <= head_cmd.reached;
      end else if (emit) begin
         left_ff <= left_in;
      end
      if (emit) begin
         o_value_ff   <= value_ff;
         o_copies_ff  <= chunk[COPIES_W-1:0];
         o_last_ff    <= final_chunk;
         o_reached_ff <= final_chunk && reached_ff;
      end
   end

   assign out_valid      = vld_ff;
   assign out_value      = o_value_ff;
   assign copies         = o_copies_ff;
   assign last_of_item   = o_last_ff;
   assign length_reached = o_reached_ff;

endmodule

@@ tb/rle_pair_escape_decoder_test.sv @@
// Self-checking testbench for rle_pair_escape_decoder: a directed table, then random
// escape sequences, checked chunk by chunk against a built-in decoder model.
// Depends on rled_pkg, the rled_ channel interfaces and the decoder RTL.
module rle_pair_escape_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rled_pkg::*;

   localparam int LW           = DEF_LENGTH_WIDTH;
   localparam int RUN_CHUNK    = (DEF_COPIES_PER_RESULT < 8) ? 8 :
                                 ((DEF_COPIES_PER_RESULT > 15) ? 15 : DEF_COPIES_PER_RESULT);
   localparam logic [LW-1:0] MAX_LEN = {LW{1'b1}};
   localparam int SETTLE       = 8;     // command load plus margin
   localparam int HOLD_CYCLES  = 250;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 80;

   typedef struct packed {
      logic [BYTE_W-1:0]   value;
      logic [COPIES_W-1:0] copies;
      logic                last;
      logic                reached;
   } run_chunk_type;

   typedef enum logic [1:0] {ROW_ITEM, ROW_LENGTH, ROW_LENGTH_PLUS, ROW_HOLD} row_kind_type;

   // typed rows carry their own expectation: none, or exactly one chunk
   typedef struct packed {
      row_kind_type        kind;
      logic [LW-1:0]       arg;
      logic                eos;
      logic                typed;
      logic                one_result;
      logic [BYTE_W-1:0]   t_value;
      logic [COPIES_W-1:0] t_copies;
      logic                t_reached;
   } plan_row_type;

   localparam int PLAN_ROWS = 33;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // after reset, length 0: nothing comes out
      '{ROW_LENGTH,      24'd0,     1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h41,    1'b0, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'hBE,    1'b1, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
      // length 40: literal, zero count, chunked run, flushes, clipped run
      '{ROW_LENGTH,      24'd40,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h00,    1'b0, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'hFF,    1'b0, 1'b1, 1'b1, 8'h00, 4'd1, 1'b0},
      '{ROW_ITEM,        24'hFF,    1'b0, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h00,    1'b0, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h7E,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h7E,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h14,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h55,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h00,    1'b1, 1'b1, 1'b1, 8'h55, 4'd1, 1'b0},
      '{ROW_ITEM,        24'hAA,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'hAA,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'hFF,    1'b1, 1'b1, 1'b1, 8'hAA, 4'd2, 1'b0},
      '{ROW_ITEM,        24'h01,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h01,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'hFF,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      // full length: longest run while the receiver holds off
      '{ROW_LENGTH,      24'hFFFFFF, 1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_HOLD,        24'd0,     1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h80,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h80,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'hFF,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h12,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h34,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h34,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h00,    1'b1, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      // one byte of room: pending pair flushes as a single copy, then input is dropped
      '{ROW_LENGTH_PLUS, 24'd1,     1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h9C,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h9C,    1'b0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
      '{ROW_ITEM,        24'h63,    1'b1, 1'b1, 1'b1, 8'h9C, 4'd1, 1'b1},
      '{ROW_ITEM,        24'hC3,    1'b0, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0}
   };

   logic clock;
   logic reset;

   rled_req_if                          req_chan ();
   rled_rsp_if                          rsp_chan ();
   rled_csr_if #(.LENGTH_WIDTH(LW))     csr_chan ();

   rle_pair_escape_decoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // decoder model state
   logic [LW-1:0]     length_cfg;
   logic [LW-1:0]     made_count;
   logic [BYTE_W-1:0] held_val;
   phase_type         pair_phase;
   run_chunk_type     chunks_due[$];

   int  fails;
   int  items_sent;
   int  useful_items;
   int  chunks_seen;
   int  length_writes;
   bit  gaps_on;
   bit  stalls_on;
   bit  hold_ask;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // clip a run at the configured length and cut it into chunks
   function automatic void add_run(input logic [BYTE_W-1:0] v, input int unsigned cnt,
                                   ref run_chunk_type fresh[$]);
      int unsigned   room;
      int unsigned   c;
      run_chunk_type r;
      if (made_count >= length_cfg) return;
      room = length_cfg - made_count;
      if (cnt > room) cnt = room;
      while (cnt > 0) begin
         c = (cnt < RUN_CHUNK) ? cnt : RUN_CHUNK;
         made_count = made_count + LW'(c);
         r.value   = v;
         r.copies  = COPIES_W'(c);
         r.last    = 1'b0;
         r.reached = (made_count == length_cfg);
         fresh.push_back(r);
         cnt -= c;
      end
   endfunction

   function automatic void decode_item(input logic [BYTE_W-1:0] b, input logic eos,
                                       ref run_chunk_type fresh[$]);
      if (eos) begin
         if (pair_phase == PH_HELD) add_run(held_val, 1, fresh);
         else if (pair_phase == PH_COUNT) add_run(held_val, 2, fresh);
         pair_phase = PH_EMPTY;
      end else if (made_count < length_cfg) begin
         case (pair_phase)
            PH_HELD: begin
               if (b == held_val) begin
                  pair_phase = PH_COUNT;
               end else begin
                  add_run(held_val, 1, fresh);
                  held_val = b;
               end
            end
            PH_COUNT: begin
               add_run(held_val, b, fresh);
               pair_phase = PH_EMPTY;
            end
            default: begin
               held_val   = b;
               pair_phase = PH_HELD;
            end
         endcase
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
   endfunction

   function automatic void check_chunk(input run_chunk_type got);
      run_chunk_type want;
      if (chunks_due.size() == 0) begin
         $error("unexpected chunk: value %0h copies %0d", got.value, got.copies);
         fails++;
         return;
      end
      want = chunks_due.pop_front();
      if (got.value !== want.value) begin
         $error("out_value: expected %0h, got %0h", want.value, got.value);
         fails++;
      end
      if (got.copies !== want.copies) begin
         $error("copies: expected %0d, got %0d", want.copies, got.copies);
         fails++;
      end
      if (got.last !== want.last) begin
         $error("last_of_item: expected %0b, got %0b", want.last, got.last);
         fails++;
      end
      if (got.reached !== want.reached) begin
         $error("length_reached: expected %0b, got %0b", want.reached, got.reached);
         fails++;
      end
   endfunction

   function automatic logic [BYTE_W-1:0] run_count();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r < 8) return BYTE_W'($urandom_range(1, 20));
      return BYTE_W'($urandom_range(21, 255));
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.in_byte       <= b;
      req_chan.end_of_stream <= eos;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic feed(input logic [BYTE_W-1:0] b, input logic eos);
      run_chunk_type fresh[$];
      if (eos || made_count < length_cfg) useful_items++;
      send_byte(b, eos);
      decode_item(b, eos, fresh);
      foreach (fresh[k]) chunks_due.push_back(fresh[k]);
   endtask

   // drop valid, let every expected chunk arrive, then let the front settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (chunks_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_length(input logic [LW-1:0] v);
      drain();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= v;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      length_cfg = v;
      length_writes++;
   endtask

   // mostly well-formed pairs with counts and literals, some flushes and noise
   task automatic random_traffic(input int goal, input int tries);
      int                first_useful;
      int                first_sent;
      int                pick;
      logic [BYTE_W-1:0] v;
      first_useful = useful_items;
      first_sent   = items_sent;
      while (useful_items - first_useful < goal && items_sent - first_sent < tries) begin
         pick = $urandom_range(0, 9);
         v    = BYTE_W'($urandom());
         if (pick < 5) begin
            feed(v, 1'b0);
            feed(v, 1'b0);
            feed(run_count(), 1'b0);
         end else if (pick < 8) begin
            feed(v, 1'b0);
         end else if (pick == 8) begin
            feed(v, 1'b1);
         end else begin
            repeat ($urandom_range(1, 3))
               feed(BYTE_W'($urandom()), $urandom_range(0, 3) == 0);
         end
      end
   endtask

   // receiver: check each transfer, stall in short bursts, or hold off on request
   initial begin : sink_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            check_chunk('{rsp_chan.out_value, rsp_chan.copies,
                          rsp_chan.last_of_item, rsp_chan.length_reached});
            chunks_seen++;
         end
         if (hold_ask) begin
            hold_ask  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // end the run when no channel has moved for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("rle_pair_escape_decoder_test NOT OK");
      $finish;
   end

   initial begin : stimulus
      run_chunk_type scratch[$];
      int            directed_items;
      fails         = 0;
      items_sent    = 0;
      useful_items  = 0;
      chunks_seen   = 0;
      length_writes = 0;
      hold_ask      = 1'b0;
      gaps_on       = 1'b1;
      stalls_on     = 1'b1;
      length_cfg    = '0;
      made_count    = '0;
      held_val      = '0;
      pair_phase    = PH_EMPTY;

      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.in_byte       <= '0;
      req_chan.end_of_stream <= 1'b0;
      csr_chan.valid         <= 1'b0;
      csr_chan.data          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_ROWS; i++) begin
         case (PLAN[i].kind)
            ROW_LENGTH:      write_length(PLAN[i].arg);
            ROW_LENGTH_PLUS: write_length(made_count + PLAN[i].arg);
            ROW_HOLD:        hold_ask = 1'b1;
            default: begin
               if (PLAN[i].typed) begin
                  send_byte(PLAN[i].arg[BYTE_W-1:0], PLAN[i].eos);
                  scratch.delete();
                  decode_item(PLAN[i].arg[BYTE_W-1:0], PLAN[i].eos, scratch);
                  if (PLAN[i].one_result)
                     chunks_due.push_back('{PLAN[i].t_value, PLAN[i].t_copies, 1'b1,
                                            PLAN[i].t_reached});
               end else begin
                  feed(PLAN[i].arg[BYTE_W-1:0], PLAN[i].eos);
               end
            end
         endcase
      end
      directed_items = items_sent;

      // random part: open length, clipping, lowered length, then no idling at all
      useful_items = 0;
      write_length(MAX_LEN);
      hold_ask = 1'b1;
      random_traffic(20, 25);
      write_length(LW'(made_count + $urandom_range(0, 60)));
      random_traffic(20, 15);
      write_length(LW'(made_count - $urandom_range(1, 200)));
      random_traffic(20, 5);
      write_length(LW'(made_count + $urandom_range(100, 400)));
      random_traffic(20, 25);
      write_length(MAX_LEN);
      random_traffic(RANDOM_ITEMS - useful_items - 25, 400);
      drain();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      random_traffic(RANDOM_ITEMS - useful_items, 400);
      drain();

      $display("Covered %0d input transfers (%0d from the directed table), %0d chunks checked,",
               items_sent, directed_items, chunks_seen);
      $display("%0d length writes, %0d bytes decoded, two long receiver hold-offs.",
               length_writes, made_count);
      if (fails == 0)
         $display("rle_pair_escape_decoder_test OK");
      else
         $display("rle_pair_escape_decoder_test NOT OK");
      $finish;
   end

endmodule
